// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the backoff window RTL.
// Needs clk and rst_n in scope at the point of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is asserted.
`define LAB_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Condition that must never be true on a clock edge.
`define LAB_ASSERT_NEVER(label, expr, msg) \
    `LAB_ASSERT(label, !(expr), msg)

`endif

// ===== hw/rtl/lab_pkg.sv =====
// Package for the load aware backoff window: widths, codes, config and
// divider types, constant helpers. No dependencies.
package lab_pkg;

    localparam int unsigned BO_W        = 17;
    localparam int unsigned ID_W        = 32;
    localparam int unsigned PCT_W       = 7;
    localparam int unsigned SRC_W       = 8;
    localparam int unsigned MODE_W      = 2;
    localparam int unsigned CFG_IDX_W   = 3;

    localparam int unsigned START_BO_DEF = 16;
    localparam int unsigned MAX_BO_DEF   = 65536;
    localparam logic [ID_W-1:0] LAST_ID_RST = 32'd999;
    localparam logic [BO_W-1:0] MIN_WIN_RST = 17'd16;

    // tx share arithmetic
    localparam int unsigned TX_SCALE    = 1000;
    localparam int unsigned TX_NUM      = 100000;
    localparam int unsigned DIV_NUM_W   = 17;          // holds TX_NUM
    localparam int unsigned DIV_DEN_W   = SRC_W + 1;   // source_count + 1
    localparam int unsigned WANT_W      = 16;          // quotient <= 50000
    localparam int unsigned HAVE_W      = 17;          // 1000 * 127
    localparam logic [WANT_W-1:0] DIV10_MUL = 16'd52429;
    localparam int unsigned DIV10_SHIFT = 19;
    localparam int unsigned SLACK_W     = 2 * WANT_W - DIV10_SHIFT;

    // busy mode: target / 20 as (v * 205) >> 12, exact for 7-bit v
    localparam int unsigned BUSY_DIV_MUL   = 205;
    localparam int unsigned BUSY_DIV_SHIFT = 12;
    localparam int unsigned BUSY_PROD_W    = PCT_W + 8;

    localparam logic [PCT_W-1:0] DIFF_MARGIN = 7'd5;

    typedef enum logic [MODE_W-1:0] {
        MODE_BUSY     = 2'd0,
        MODE_DIFF     = 2'd1,
        MODE_TX       = 2'd2,
        MODE_BUSY_ALT = 2'd3
    } mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MODE        = 3'd0,
        REG_TARGET_BUSY = 3'd1,
        REG_TARGET_DIFF = 3'd2,
        REG_CAP_ENABLE  = 3'd3,
        REG_SYNC_ENABLE = 3'd4,
        REG_MIN_WINDOW  = 3'd5
    } reg_idx_t;

    typedef struct packed {
        mode_t             mode;
        logic [PCT_W-1:0]  target_busy;
        logic [PCT_W-1:0]  target_diff;
        logic              cap_enable;
        logic              sync_enable;
        logic [BO_W-1:0]   min_window;
    } cfg_t;

    typedef struct packed {
        logic                 start;
        logic [DIV_DEN_W-1:0] divisor;
    } div_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_sts_t;

    typedef enum logic [1:0] {
        S_IDLE   = 2'd0,
        S_DIV    = 2'd1,
        S_SCALE  = 2'd2,
        S_DECIDE = 2'd3
    } state_t;

    function automatic logic [PCT_W-1:0] div20(input logic [PCT_W-1:0] v);
        logic [BUSY_PROD_W-1:0] p;
        p = BUSY_PROD_W'(v) * BUSY_PROD_W'(BUSY_DIV_MUL);
        return PCT_W'(p >> BUSY_DIV_SHIFT);
    endfunction

endpackage

// ===== hw/rtl/load_aware_backoff_window.sv =====
// Load aware backoff window: adapts a power-of-two backoff from channel
// statistics words and returns contention_window = backoff - 1.
// Uses lab_pkg, lab_regs, lab_div and assert_macros.svh.
//
// Channels: the cfg channel writes register cfg_index with cfg_data (always
// ready; write it only while the block is idle). The input channel takes one
// statistics word per handshake; the output channel returns one word each.
// In tx mode with sources, a word passes the serial divide of 100000 by
// (source_count + 1), a scale step and the decide step; in the other modes,
// and in tx mode with no sources, it goes straight to the decide step. One
// word is in work at a time, so a new word is taken only once the last one
// has left the decide step.
// The result sits in an output register: while the receiver stalls, the
// block still takes the next word and finishes it, then holds it in the
// decide step until the output register frees up.
// Reset: backoff = START_BO, last snapshot id = 999, mode = tx share, both
// targets 0, cap and sync off, min_window = 16. No clearing pass.
`include "assert_macros.svh"

module load_aware_backoff_window #(
    parameter int unsigned START_BO = lab_pkg::START_BO_DEF,
    parameter int unsigned MAX_BO   = lab_pkg::MAX_BO_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [lab_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [lab_pkg::BO_W-1:0]          cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [lab_pkg::ID_W-1:0]          snapshot_id,
    input  logic [lab_pkg::PCT_W-1:0]         busy_pct,
    input  logic [lab_pkg::PCT_W-1:0]         rx_pct,
    input  logic [lab_pkg::PCT_W-1:0]         tx_pct,
    input  logic [lab_pkg::PCT_W-1:0]         mac_tx_share,
    input  logic [lab_pkg::SRC_W-1:0]         source_count,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [lab_pkg::BO_W-1:0]   contention_window
);
    import lab_pkg::*;

    localparam logic [BO_W-1:0] BO_RST = BO_W'(START_BO);
    localparam logic [BO_W:0]   BO_MAX = (BO_W + 1)'(MAX_BO);

    cfg_t      cfg;
    div_ctl_t  div_ctl;
    div_sts_t  div_sts;
    logic [DIV_NUM_W-1:0] quotient;

    state_t                state_reg, state_next;
    logic                  accept;
    logic                  commit;

    // captured word
    logic [ID_W-1:0]       id_reg;
    logic [PCT_W-1:0]      busy_pct_reg, rx_pct_reg, tx_pct_reg, share_reg;
    logic [SRC_W-1:0]      src_reg;

    // tx share terms
    logic [WANT_W-1:0]     want;
    logic [2*WANT_W-1:0]   slack_prod;
    logic [SLACK_W-1:0]    slack_reg;
    logic [HAVE_W-1:0]     have_reg;

    // block state
    logic [BO_W-1:0]       backoff_reg, backoff_next;
    logic [ID_W-1:0]       last_id_reg;
    logic                  out_valid_reg;
    logic [BO_W-1:0]       cw_reg;
    logic                  skip;

    lab_regs u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    lab_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (div_ctl),
        .dividend (DIV_NUM_W'(TX_NUM)),
        .sts      (div_sts),
        .quotient (quotient)
    );

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign commit    = (state_reg == S_DECIDE) && (!out_valid_reg || out_ready);

    // serial divide only in tx mode with at least one source
    assign div_ctl.start   = accept && (cfg.mode == MODE_TX) && (source_count != '0);
    assign div_ctl.divisor = DIV_DEN_W'(source_count) + 1'b1;

    assign want       = quotient[WANT_W-1:0];
    assign slack_prod = (2*WANT_W)'(want) * (2*WANT_W)'(DIV10_MUL);

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                    state_next = div_ctl.start ? S_DIV : S_DECIDE;
            end
            S_DIV:
            begin
                if (div_sts.done)
                    state_next = S_SCALE;
            end
            S_SCALE:  state_next = S_DECIDE;
            S_DECIDE:
            begin
                if (commit)
                    state_next = S_IDLE;
            end
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            id_reg       <= snapshot_id;
            busy_pct_reg <= busy_pct;
            rx_pct_reg   <= rx_pct;
            tx_pct_reg   <= tx_pct;
            share_reg    <= mac_tx_share;
            src_reg      <= source_count;
        end
        if (state_reg == S_SCALE)
        begin
            // want/10 by reciprocal, and 1000 * share
            slack_reg <= slack_prod[2*WANT_W-1:DIV10_SHIFT];
            have_reg  <= HAVE_W'(share_reg) * HAVE_W'(TX_SCALE);
        end
    end

    // decide: halve, double or keep, then optional cap
    always_comb
    begin
        logic [PCT_W:0]    own;
        logic [PCT_W-1:0]  diff;
        logic [PCT_W-1:0]  lo;
        logic [PCT_W:0]    hi;
        logic [HAVE_W-1:0] thr;
        logic [BO_W:0]     dbl;
        logic [BO_W-1:0]   half;
        logic [BO_W-1:0]   step;
        logic              do_half;
        logic              do_dbl;

        own  = {1'b0, rx_pct_reg} + {1'b0, tx_pct_reg};
        diff = ({1'b0, busy_pct_reg} > own) ? PCT_W'({1'b0, busy_pct_reg} - own) : '0;
        lo   = (cfg.target_diff > DIFF_MARGIN) ? cfg.target_diff - DIFF_MARGIN : '0;
        hi   = {1'b0, cfg.target_diff} + {1'b0, DIFF_MARGIN};
        thr  = HAVE_W'(want) - HAVE_W'(slack_reg);

        half = backoff_reg >> 1;
        dbl  = {backoff_reg, 1'b0};
        if (dbl > BO_MAX)
            dbl = BO_MAX;

        do_half = 1'b0;
        do_dbl  = 1'b0;
        case (cfg.mode) inside
            MODE_DIFF:
            begin
                if (diff < lo)
                    do_half = 1'b1;
                else if ({1'b0, diff} > hi)
                    do_dbl = 1'b1;
            end
            MODE_TX:
            begin
                if (src_reg != '0)
                begin
                    if (have_reg < thr)
                        do_half = 1'b1;
                    else if (have_reg > HAVE_W'(want))
                        do_dbl = 1'b1;
                end
            end
            MODE_BUSY, MODE_BUSY_ALT:
            begin
                // halve below target minus 5%, never below one
                if ((busy_pct_reg < cfg.target_busy - div20(cfg.target_busy)) &&
                    (backoff_reg > BO_W'(1)))
                    do_half = 1'b1;
                else if (busy_pct_reg > cfg.target_busy)
                    do_dbl = 1'b1;
            end
            default:
            begin
                do_half = 1'b0;
                do_dbl  = 1'b0;
            end
        endcase

        step = do_half ? half : (do_dbl ? dbl[BO_W-1:0] : backoff_reg);
        if (cfg.cap_enable && (step < cfg.min_window))
            step = cfg.min_window;

        // repeated snapshot id with sync on: keep everything
        skip         = cfg.sync_enable && (id_reg == last_id_reg);
        backoff_next = skip ? backoff_reg : step;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            backoff_reg   <= BO_RST;
            last_id_reg   <= LAST_ID_RST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (commit)
            begin
                backoff_reg <= backoff_next;
                if (!skip)
                    last_id_reg <= id_reg;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit)
            cw_reg <= backoff_next - 1'b1;
    end

    assign out_valid         = out_valid_reg;
    assign contention_window = $signed(cw_reg);

    `LAB_ASSERT(a_bo_commit_only, !commit |=> $stable(backoff_reg), "backoff moved without a commit")
    `LAB_ASSERT(a_div_running, (state_reg == S_DIV) |-> div_sts.busy, "waiting on an idle divider")
    `LAB_ASSERT_NEVER(a_div_restart, div_ctl.start && div_sts.busy, "divider restarted while busy")

endmodule

// ===== hw/rtl/lab_div.sv =====
// Restoring shift/subtract divider, one quotient bit per cycle.
// Depends on lab_pkg and assert_macros.svh.
`include "assert_macros.svh"

module lab_div (
    input  logic                            clk,
    input  logic                            rst_n,
    input  lab_pkg::div_ctl_t               ctl,
    input  logic [lab_pkg::DIV_NUM_W-1:0]   dividend,
    output lab_pkg::div_sts_t               sts,
    output logic [lab_pkg::DIV_NUM_W-1:0]   quotient
);
    import lab_pkg::*;

    localparam int unsigned CNT_W = $clog2(DIV_NUM_W + 1);

    logic                 busy_reg, busy_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [DIV_DEN_W-1:0] rem_reg, rem_next;
    logic [DIV_DEN_W-1:0] den_reg, den_next;
    logic [DIV_NUM_W-1:0] quo_reg, quo_next;
    logic [DIV_DEN_W:0]   part;
    logic [DIV_DEN_W:0]   diff;
    logic                 fits;

    assign part = {rem_reg, quo_reg[DIV_NUM_W-1]};
    assign fits = part >= {1'b0, den_reg};
    assign diff = part - {1'b0, den_reg};

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        quo_next  = quo_reg;
        if (ctl.start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DIV_NUM_W);
            rem_next  = '0;
            den_next  = ctl.divisor;
            quo_next  = dividend;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[DIV_DEN_W-1:0] : part[DIV_DEN_W-1:0];
            quo_next = {quo_reg[DIV_NUM_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        quo_reg <= quo_next;
    end

    // done: last quotient bit is shifted in at this edge
    assign sts.busy = busy_reg;
    assign sts.done = busy_reg && (cnt_reg == CNT_W'(1));
    assign quotient = quo_reg;

    `LAB_ASSERT(a_div_done_ends, sts.done |=> !sts.busy, "divider still busy after done")
    `LAB_ASSERT(a_div_cnt_live, busy_reg |-> (cnt_reg != '0), "divider busy with zero count")
    `LAB_ASSERT(a_div_start_load, ctl.start |=> (busy_reg && (cnt_reg == CNT_W'(DIV_NUM_W))), "divider start did not load")

endmodule

// ===== hw/rtl/lab_regs.sv =====
// Configuration register bank for the backoff window block.
// Depends on lab_pkg.
module lab_regs (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    input  logic [lab_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [lab_pkg::BO_W-1:0]        cfg_data,
    output lab_pkg::cfg_t                   cfg
);
    import lab_pkg::*;

    cfg_t cfg_reg, cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (reg_idx_t'(cfg_index))
                REG_MODE:        cfg_next.mode        = mode_t'(cfg_data[MODE_W-1:0]);
                REG_TARGET_BUSY: cfg_next.target_busy = cfg_data[PCT_W-1:0];
                REG_TARGET_DIFF: cfg_next.target_diff = cfg_data[PCT_W-1:0];
                REG_CAP_ENABLE:  cfg_next.cap_enable  = cfg_data[0];
                REG_SYNC_ENABLE: cfg_next.sync_enable = cfg_data[0];
                REG_MIN_WINDOW:  cfg_next.min_window  = cfg_data;
                default:         cfg_next = cfg_reg;   // unused indexes
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode        <= MODE_TX;
            cfg_reg.target_busy <= '0;
            cfg_reg.target_diff <= '0;
            cfg_reg.cap_enable  <= 1'b0;
            cfg_reg.sync_enable <= 1'b0;
            cfg_reg.min_window  <= MIN_WIN_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule
